// ----- rtl/keypad_scan_debounce_long_press_assert.svh -----
// Assertion macros for the keypad scanner.
// Both expect clk and rst_n in scope; checks are off while reset is held.
`ifndef KEYPAD_SCAN_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define KEYPAD_SCAN_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// Same-cycle implication
`define KSD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad scanner check failed");

// Next-cycle implication
`define KSD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad scanner check failed");

`endif

// ----- rtl/ksd_pkg.sv -----
package ksd_pkg;

  // Keypad geometry
  localparam int ROWS  = 4;
  localparam int COLS  = 4;
  localparam int KEYS  = ROWS * COLS;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int KEY_W = $clog2(KEYS);

  // Hold counters and thresholds
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] SHORT_RESET = 16'd3;
  localparam logic [CNT_W-1:0] LONG_RESET  = 16'd50;

  // Job queue between scan front and event back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SHORT_PRESS = 1'b0,
    CFG_LONG_PRESS  = 1'b1
  } ksd_cfg_idx_t;

  // Event kinds
  typedef enum logic {
    EV_SHORT = 1'b0,
    EV_LONG  = 1'b1
  } ksd_kind_t;

  // One tick's worth of events: key bits in row-major order, kind per row
  typedef struct packed {
    logic [KEYS-1:0] key_mask;
    logic [ROWS-1:0] long_rows;
  } ksd_job_t;

  // Job handoff with its valid flag
  typedef struct packed {
    logic     valid;
    ksd_job_t job;
  } ksd_jobv_t;

endpackage

// ----- rtl/ksd_front.sv -----
`include "keypad_scan_debounce_long_press_assert.svh"

module ksd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [ksd_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ksd_pkg::ROWS-1:0]      in_row_levels,
  input  logic [ksd_pkg::KEYS-1:0]      in_probe_levels,
  output ksd_pkg::ksd_jobv_t            push,
  input  logic                          push_ready
);
  import ksd_pkg::*;

  logic [CNT_W-1:0] short_r, long_r;
  logic [CNT_W-1:0] cnt_r   [ROWS];
  logic [CNT_W-1:0] cnt_nxt [ROWS];
  logic [CNT_W-1:0] cnt_inc [ROWS];
  logic [ROWS-1:0]  fire_short, fire_long;
  logic             accept;

  // A tick is taken whenever the queue can hold its job
  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= SHORT_RESET;
      long_r  <= LONG_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SHORT_PRESS) short_r <= cfg_wdata;
      if (cfg_index == CFG_LONG_PRESS)  long_r  <= cfg_wdata;
    end
  end

  // Per-row hold counting and threshold match
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      cnt_inc[r]    = cnt_r[r] + 1'b1;
      cnt_nxt[r]    = cnt_r[r];
      fire_short[r] = 1'b0;
      fire_long[r]  = 1'b0;
      if (accept) begin
        if (!in_row_levels[r]) begin
          // saturated counter holds and fires nothing
          if (cnt_r[r] != CNT_MAX) begin
            cnt_nxt[r] = cnt_inc[r];
            if (cnt_inc[r] == short_r) begin
              fire_short[r] = 1'b1;
            end else if (cnt_inc[r] == long_r) begin
              fire_long[r] = 1'b1;
            end
          end
        end else begin
          cnt_nxt[r] = '0;
        end
      end
    end
  end

  // Build the job: probed keys of every row that fired
  always_comb begin
    push.job.long_rows = fire_long;
    for (int r = 0; r < ROWS; r++) begin
      push.job.key_mask[r*COLS +: COLS] =
        (fire_short[r] || fire_long[r]) ? in_probe_levels[r*COLS +: COLS] : '0;
    end
    push.valid = accept && (|push.job.key_mask);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) cnt_r[r] <= '0;
    end else begin
      for (int r = 0; r < ROWS; r++) cnt_r[r] <= cnt_nxt[r];
    end
  end

  // A released row starts over from zero
  `KSD_ASSERT_NXT(a_release_clears, accept && in_row_levels[0], cnt_r[0] == '0)

endmodule

// ----- rtl/ksd_queue.sv -----
`include "keypad_scan_debounce_long_press_assert.svh"

module ksd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  ksd_pkg::ksd_jobv_t push,
  output logic               push_ready,
  output ksd_pkg::ksd_jobv_t head,
  input  logic               pop
);
  import ksd_pkg::*;

  ksd_job_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.job   = mem_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && head.valid;

  // Job storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.job;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  `KSD_ASSERT_IMP(a_no_overflow, push.valid, push_ready)
  `KSD_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= QCNT_W'(QDEPTH))

endmodule

// ----- rtl/ksd_back.sv -----
`include "keypad_scan_debounce_long_press_assert.svh"

module ksd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ksd_pkg::ksd_jobv_t        head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_event_kind,
  output logic [ksd_pkg::ROW_W-1:0] out_key_row,
  output logic [ksd_pkg::COL_W-1:0] out_key_col,
  output logic                      out_last_event
);
  import ksd_pkg::*;

  logic            cur_valid_r;
  logic [KEYS-1:0] cur_mask_r;
  logic [ROWS-1:0] cur_long_r;
  logic            out_valid_r, out_kind_r, out_last_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;

  logic [KEYS-1:0]  low_bit, rest_mask;
  logic [KEY_W-1:0] key_idx;
  logic [ROW_W-1:0] sel_row;
  logic             out_free, emit, last;

  // Lowest pending key goes first: row order, then column order
  assign low_bit   = cur_mask_r & (~cur_mask_r + 1'b1);
  assign rest_mask = cur_mask_r & ~low_bit;
  assign last      = (rest_mask == '0);

  always_comb begin
    key_idx = '0;
    for (int k = 0; k < KEYS; k++) begin
      if (low_bit[k]) key_idx = KEY_W'(k);
    end
  end

  assign sel_row  = key_idx[KEY_W-1:COL_W];
  assign out_free = !out_valid_r || out_ready;
  assign emit     = cur_valid_r && out_free;
  assign pop      = head.valid && (!cur_valid_r || (emit && last));

  // Working job register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
    end else if (emit && last) begin
      cur_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_mask_r <= head.job.key_mask;
      cur_long_r <= head.job.long_rows;
    end else if (emit) begin
      cur_mask_r <= rest_mask;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= cur_long_r[sel_row] ? EV_LONG : EV_SHORT;
      out_row_r  <= sel_row;
      out_col_r  <= key_idx[COL_W-1:0];
      out_last_r <= last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_key_row    = out_row_r;
  assign out_key_col    = out_col_r;
  assign out_last_event = out_last_r;

  // A live job always has a key left to send
  `KSD_ASSERT_IMP(a_job_nonempty, cur_valid_r, cur_mask_r != '0)
  // Finishing a job with nothing queued leaves the back end idle
  `KSD_ASSERT_NXT(a_idle_after_last, emit && last && !head.valid, !cur_valid_r)

endmodule

// ----- rtl/keypad_scan_debounce_long_press.sv -----
// A tick's job passes through the job queue and the working job register to the output register.
// Event beats leave at one per cycle while out_ready is high; a tick's events go out in turn.
// Scan ticks are taken every cycle while the two-entry job queue has room.
// Reset (rst_n low, synchronous): hold counters cleared, thresholds back to 3 and 50,
// queue and output emptied.
module keypad_scan_debounce_long_press (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [ksd_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ksd_pkg::ROWS-1:0]  in_row_levels,
  input  logic [ksd_pkg::KEYS-1:0]  in_probe_levels,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_event_kind,
  output logic [ksd_pkg::ROW_W-1:0] out_key_row,
  output logic [ksd_pkg::COL_W-1:0] out_key_col,
  output logic                      out_last_event
);
  import ksd_pkg::*;

  ksd_jobv_t push, head;
  logic      push_ready, pop;

  // Scan front: counters, thresholds, job build
  ksd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_row_levels   (in_row_levels),
    .in_probe_levels (in_probe_levels),
    .push            (push),
    .push_ready      (push_ready)
  );

  // Job queue
  ksd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  // Event serializer
  ksd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_key_row    (out_key_row),
    .out_key_col    (out_key_col),
    .out_last_event (out_last_event)
  );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import ksd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  // One key event as it leaves the block
  typedef struct packed {
    ksd_kind_t        kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } key_event_t;

  // Tracks hold counters and thresholds, predicts the events of each tick
  class key_event_scoreboard;
    logic [CNT_W-1:0] hold_count[ROWS];
    logic [CNT_W-1:0] short_thr;
    logic [CNT_W-1:0] long_thr;
    key_event_t       expected_events[$];
    int               errors;
    int               events_checked;

    function new();
      for (int r = 0; r < ROWS; r++) hold_count[r] = '0;
      short_thr = SHORT_RESET;
      long_thr = LONG_RESET;
      errors = 0;
      events_checked = 0;
    endfunction

    function void set_threshold(ksd_cfg_idx_t idx, logic [CNT_W-1:0] value);
      if (idx == CFG_SHORT_PRESS) short_thr = value;
      else long_thr = value;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    // Advance counters by one scan tick and queue the events it fires
    function void note_tick(logic [ROWS-1:0] rows, logic [KEYS-1:0] probe);
      key_event_t held_ev;
      key_event_t ev;
      bit         have;
      bit         fire;
      ksd_kind_t  kind;
      int         n;
      have = 0;
      n = 0;
      kind = EV_SHORT;
      for (int r = 0; r < ROWS; r++) begin
        fire = 0;
        if (!rows[r]) begin
          // saturated counters stay put and fire nothing
          if (hold_count[r] != CNT_MAX) begin
            hold_count[r] = hold_count[r] + 16'd1;
            if (hold_count[r] == short_thr) begin
              fire = 1;
              kind = EV_SHORT;
            end else if (hold_count[r] == long_thr) begin
              fire = 1;
              kind = EV_LONG;
            end
          end
        end else begin
          hold_count[r] = '0;
        end
        if (fire) begin
          for (int c = 0; c < COLS; c++) begin
            if (probe[r*COLS+c] && n < KEYS) begin
              ev.kind = kind;
              ev.row = r[ROW_W-1:0];
              ev.col = c[COL_W-1:0];
              ev.last = 1'b0;
              if (have) expected_events.push_back(held_ev);
              held_ev = ev;
              have = 1;
              n++;
            end
          end
        end
      end
      // final event of the tick carries the last flag
      if (have) begin
        held_ev.last = 1'b1;
        expected_events.push_back(held_ev);
      end
    endfunction

    function void report(string field, int exp_val, int act_val);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
    endfunction

    // Compare one event beat with the oldest expectation
    function void check_event(logic kind, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                              logic last);
      key_event_t exp_ev;
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event, expected none, actual kind=%0d row=%0d",
                 $time, kind, row);
        $display("%0t: unexpected event continued, col=%0d last=%0d", $time, col, last);
        return;
      end
      exp_ev = expected_events.pop_front();
      events_checked++;
      if (exp_ev.kind != kind) report("event_kind", exp_ev.kind, kind);
      if (exp_ev.row != row) report("key_row", exp_ev.row, row);
      if (exp_ev.col != col) report("key_col", exp_ev.col, col);
      if (exp_ev.last != last) report("last_event", exp_ev.last, last);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ROWS-1:0]     in_row_levels = '1;
  logic [KEYS-1:0]     in_probe_levels = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_event_kind;
  logic [ROW_W-1:0]    out_key_row;
  logic [COL_W-1:0]    out_key_col;
  logic                out_last_event;

  key_event_scoreboard sb;
  bit                  burst = 0;
  int                  ticks_sent = 0;
  int                  cfg_writes = 0;
  int                  idle_cycles = 0;

  keypad_scan_debounce_long_press u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_row_levels   (in_row_levels),
    .in_probe_levels (in_probe_levels),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_key_row     (out_key_row),
    .out_key_col     (out_key_col),
    .out_last_event  (out_last_event)
  );

  always #5 clk = ~clk;

  // Wait before a beat; zero throughout a burst
  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  // Beat monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_tick(in_row_levels, in_probe_levels);
    if (rst_n && out_valid && out_ready)
      sb.check_event(out_event_kind, out_key_row, out_key_col, out_last_event);
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Event sink with random stalls
  initial begin : event_sink
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Send one scan tick; called and returns at a falling edge
  task automatic send_tick(input logic [ROWS-1:0] rows, input logic [KEYS-1:0] probe);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_row_levels <= rows;
    in_probe_levels <= probe;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected event is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write both thresholds while idle
  task automatic set_thresholds(input logic [CNT_W-1:0] short_val,
                                input logic [CNT_W-1:0] long_val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_SHORT_PRESS;
    cfg_wdata <= short_val;
    @(negedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_wdata <= long_val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_threshold(CFG_SHORT_PRESS, short_val);
    sb.set_threshold(CFG_LONG_PRESS, long_val);
    cfg_writes += 2;
  endtask

  // Held-row runs with random probes, some row noise mixed in
  task automatic random_phase(input int n_items);
    int             sent;
    int             run;
    int             span;
    int             flip;
    logic [ROWS-1:0] base;
    logic [ROWS-1:0] rows;
    logic [KEYS-1:0] probe;
    sent = 0;
    span = 10;
    if (sb.short_thr < 60 && sb.short_thr + 2 > span) span = sb.short_thr + 2;
    if (sb.long_thr < 60 && sb.long_thr + 2 > span) span = sb.long_thr + 2;
    while (sent < n_items) begin
      burst = ($urandom_range(0, 4) == 0);
      base = ROWS'($urandom_range(0, 15) & $urandom_range(0, 15));
      run = $urandom_range(1, span);
      for (int i = 0; i < run && sent < n_items; i++) begin
        rows = base;
        if ($urandom_range(0, 5) == 0) begin
          flip = $urandom_range(0, ROWS - 1);
          rows[flip] = ~rows[flip];
        end
        case ($urandom_range(0, 3))
          0: probe = '1;
          1: probe = '0;
          default: probe = KEYS'($urandom);
        endcase
        send_tick(rows, probe);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset thresholds: press on the third held tick
    send_tick(4'hF, 16'hFFFF);
    repeat (3) send_tick(4'h0, 16'hFFFF);

    // Press on the first tick, long press on the second
    set_thresholds(16'd1, 16'd2);
    send_tick(4'hF, 16'h0000);
    send_tick(4'h0, 16'hFFFF);
    send_tick(4'h0, 16'hA5C3);
    send_tick(4'h0, 16'hFFFF);
    send_tick(4'hF, 16'hFFFF);
    send_tick(4'hA, 16'h5A5A);
    send_tick(4'h5, 16'hFFFF);
    send_tick(4'h5, 16'h0001);

    // Equal thresholds: only the short press fires
    set_thresholds(16'd2, 16'd2);
    send_tick(4'hF, 16'h0000);
    send_tick(4'h0, 16'hFFFF);
    send_tick(4'h0, 16'hFFFF);
    send_tick(4'h0, 16'hFFFF);

    // Zero threshold never fires
    set_thresholds(16'd0, 16'd1);
    send_tick(4'hF, 16'h0000);
    send_tick(4'h0, 16'hFFFF);
    send_tick(4'h0, 16'hFFFF);
    send_tick(4'h7, 16'h8000);

    // Random runs over several threshold settings
    set_thresholds(SHORT_RESET, LONG_RESET);
    random_phase(80);
    set_thresholds(16'd1, 16'd3);
    random_phase(60);
    set_thresholds(16'hFFFF, 16'd1);
    random_phase(50);
    set_thresholds(16'd2, 16'd2);
    random_phase(50);
    set_thresholds(CNT_W'($urandom_range(1, 6)), CNT_W'($urandom_range(1, 8)));
    random_phase(60);
    settle();

    $display("Covered %0d scan ticks, %0d key events checked, %0d threshold writes.",
             ticks_sent, sb.events_checked, cfg_writes);
    $display("Thresholds from zero to full scale, equal settings, row noise and stalls.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ksd_pkg.sv
rtl/ksd_front.sv
rtl/ksd_queue.sv
rtl/ksd_back.sv
rtl/keypad_scan_debounce_long_press.sv
test/testbench.sv
